>>> src/xtd_pkg.sv
// Package for the XML text entity decoder: types, character codes and helper functions.
`default_nettype none

package xtd_pkg;

    localparam int unsigned MAX_BEATS = 4;

    // Error codes carried by a result beat
    localparam logic [1:0] ERR_NONE      = 2'd0;
    localparam logic [1:0] ERR_SEMICOLON = 2'd1;
    localparam logic [1:0] ERR_RANGE     = 2'd2;
    localparam logic [1:0] ERR_UNKNOWN   = 2'd3;

    // Character codes
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_QUOT  = 8'h22;
    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_AMP   = 8'h26;
    localparam logic [7:0] CH_APOS  = 8'h27;
    localparam logic [7:0] CH_SEMI  = 8'h3B;
    localparam logic [7:0] CH_LT    = 8'h3C;
    localparam logic [7:0] CH_GT    = 8'h3E;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_UA    = 8'h41;
    localparam logic [7:0] CH_UF    = 8'h46;
    localparam logic [7:0] CH_A     = 8'h61;
    localparam logic [7:0] CH_F     = 8'h66;
    localparam logic [7:0] CH_G     = 8'h67;
    localparam logic [7:0] CH_L     = 8'h6C;
    localparam logic [7:0] CH_M     = 8'h6D;
    localparam logic [7:0] CH_O     = 8'h6F;
    localparam logic [7:0] CH_P     = 8'h70;
    localparam logic [7:0] CH_Q     = 8'h71;
    localparam logic [7:0] CH_S     = 8'h73;
    localparam logic [7:0] CH_T     = 8'h74;
    localparam logic [7:0] CH_U     = 8'h75;
    localparam logic [7:0] CH_X     = 8'h78;

    localparam logic [20:0] CODE_LIMIT = 21'h110000;

    typedef enum logic [6:0] {
        MODE_SKIP = 7'b0000001,
        MODE_TEXT = 7'b0000010,
        MODE_NAME = 7'b0000100,
        MODE_HASH = 7'b0001000,
        MODE_DEC  = 7'b0010000,
        MODE_HEX  = 7'b0100000,
        MODE_DONE = 7'b1000000
    } xtd_mode_t;

    // Results caused by one input byte; bytes[0] goes out first
    typedef struct packed {
        logic [MAX_BEATS-1:0][7:0] bytes;
        logic [2:0]                count;
        logic                      valid;
        logic                      eot;
        logic [1:0]                err;
    } xtd_group_t;

    // bit 4 set: not a hex digit
    function automatic logic [4:0] hex_digit(input logic [7:0] b);
        logic [7:0] d;
        d = 8'd0;
        if (b >= CH_0 && b <= CH_9) begin
            d = b - CH_0;
        end
        else if (b >= CH_A && b <= CH_F) begin
            d = b - CH_A + 8'd10;
        end
        else if (b >= CH_UA && b <= CH_UF) begin
            d = b - CH_UA + 8'd10;
        end
        else begin
            d = 8'h10;
        end
        return d[4:0];
    endfunction

    function automatic xtd_group_t utf8_encode(input logic [20:0] c);
        xtd_group_t g;
        g = '0;
        g.valid = 1'b1;
        if (c == 21'd0) begin
            g.count = 3'd0;
        end
        else if (c < 21'h80) begin
            g.count    = 3'd1;
            g.bytes[0] = c[7:0];
        end
        else if (c < 21'h800) begin
            g.count    = 3'd2;
            g.bytes[0] = {3'b110, c[10:6]};
            g.bytes[1] = {2'b10, c[5:0]};
        end
        else if (c < 21'h10000) begin
            g.count    = 3'd3;
            g.bytes[0] = {4'b1110, c[15:12]};
            g.bytes[1] = {2'b10, c[11:6]};
            g.bytes[2] = {2'b10, c[5:0]};
        end
        else begin
            g.count    = 3'd4;
            g.bytes[0] = {5'b11110, c[20:18]};
            g.bytes[1] = {2'b10, c[17:12]};
            g.bytes[2] = {2'b10, c[11:6]};
            g.bytes[3] = {2'b10, c[5:0]};
        end
        return g;
    endfunction

endpackage

`default_nettype wire

>>> src/xtd_stream_if.sv
// Stream interfaces of the XML text entity decoder: raw text in, decoded beats out.
`default_nettype none

interface xtd_text_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       run_start;

    modport source (output valid, output in_byte, output run_start, input ready);
    modport sink (input valid, input in_byte, input run_start, output ready);
endinterface

interface xtd_result_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       end_of_text;
    logic [1:0] error_code;
    logic       last_of_run;

    modport source (output valid, output out_byte, output byte_valid, output end_of_text,
                    output error_code, output last_of_run, input ready);
    modport sink (input valid, input out_byte, input byte_valid, input end_of_text,
                  input error_code, input last_of_run, output ready);
endinterface

`default_nettype wire

>>> src/xtd_decode.sv
// Decoder state machine: turns one raw byte into a group of zero to four result beats.
`default_nettype none

module xtd_decode
    import xtd_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       take,
    input  wire logic [7:0] in_byte,
    input  wire logic       run_start,
    output xtd_group_t      grp
);

    xtd_mode_t       mode_reg, mode_next;
    logic [3:0][7:0] chars_reg;
    logic [2:0]      len_reg, len_next;
    logic [20:0]     code_reg, code_next;
    logic            ovf_reg, ovf_next;
    logic            char_we;

    xtd_mode_t   m0, m1;
    logic [2:0]  l0;
    logic [20:0] c0;
    logic        o0;
    logic        ends, space, is_dec;
    logic [4:0]  hexd;
    logic [24:0] acc;
    logic [3:0]  digit;
    logic        name_hit;
    logic [7:0]  name_byte;

    always_comb
    begin
        ends   = (in_byte == CH_LT) || (in_byte == CH_NUL);
        space  = (in_byte == CH_SPACE) || (in_byte == CH_TAB) ||
                 (in_byte == CH_CR) || (in_byte == CH_LF);
        is_dec = (in_byte >= CH_0) && (in_byte <= CH_9);
        hexd   = hex_digit(in_byte);

        m0 = run_start ? MODE_SKIP : mode_reg;
        l0 = run_start ? 3'd0 : len_reg;
        c0 = run_start ? 21'd0 : code_reg;
        o0 = run_start ? 1'b0 : ovf_reg;
        m1 = (m0 == MODE_SKIP && !space) ? MODE_TEXT : m0;

        // named references
        name_hit  = 1'b1;
        name_byte = 8'd0;
        if (l0 == 3'd2 && chars_reg[0] == CH_G && chars_reg[1] == CH_T) begin
            name_byte = CH_GT;
        end
        else if (l0 == 3'd2 && chars_reg[0] == CH_L && chars_reg[1] == CH_T) begin
            name_byte = CH_LT;
        end
        else if (l0 == 3'd3 && chars_reg[0] == CH_A && chars_reg[1] == CH_M &&
                 chars_reg[2] == CH_P) begin
            name_byte = CH_AMP;
        end
        else if (l0 == 3'd4 && chars_reg[0] == CH_A && chars_reg[1] == CH_P &&
                 chars_reg[2] == CH_O && chars_reg[3] == CH_S) begin
            name_byte = CH_APOS;
        end
        else if (l0 == 3'd4 && chars_reg[0] == CH_Q && chars_reg[1] == CH_U &&
                 chars_reg[2] == CH_O && chars_reg[3] == CH_T) begin
            name_byte = CH_QUOT;
        end
        else begin
            name_hit = 1'b0;
        end

        // accumulator step: x16 for hex, x8 + x2 for decimal
        digit = (m1 == MODE_HEX) ? hexd[3:0] : in_byte[3:0];
        if (m1 == MODE_HEX) begin
            acc = {c0, 4'd0} + {21'd0, digit};
        end
        else begin
            acc = {1'b0, c0, 3'd0} + {3'd0, c0, 1'b0} + {21'd0, digit};
        end

        grp       = '0;
        mode_next = m1;
        len_next  = l0;
        code_next = c0;
        ovf_next  = o0;
        char_we   = 1'b0;

        unique case (m1) inside
            MODE_SKIP:
            begin
                grp.count = 3'd0;
            end
            MODE_TEXT:
            begin
                if (ends) begin
                    grp.count = 3'd1;
                    grp.eot   = 1'b1;
                    mode_next = MODE_DONE;
                end
                else if (in_byte == CH_AMP) begin
                    len_next  = 3'd0;
                    code_next = 21'd0;
                    ovf_next  = 1'b0;
                    mode_next = MODE_NAME;
                end
                else begin
                    grp.count    = 3'd1;
                    grp.valid    = 1'b1;
                    grp.bytes[0] = in_byte;
                end
            end
            MODE_NAME:
            begin
                if (ends) begin
                    grp.count = 3'd1;
                    grp.eot   = 1'b1;
                    grp.err   = ERR_UNKNOWN;
                    mode_next = MODE_DONE;
                end
                else if (in_byte == CH_HASH && l0 == 3'd0) begin
                    mode_next = MODE_HASH;
                end
                else if (in_byte == CH_SEMI) begin
                    grp.count = 3'd1;
                    if (name_hit) begin
                        grp.valid    = 1'b1;
                        grp.bytes[0] = name_byte;
                    end
                    else begin
                        grp.err = ERR_UNKNOWN;
                    end
                    mode_next = MODE_TEXT;
                end
                else if (l0 >= 3'd4) begin
                    grp.count = 3'd1;
                    grp.err   = ERR_UNKNOWN;
                    mode_next = MODE_TEXT;
                end
                else begin
                    char_we  = 1'b1;
                    len_next = l0 + 3'd1;
                end
            end
            MODE_HASH, MODE_DEC, MODE_HEX:
            begin
                if (ends) begin
                    grp.count = 3'd1;
                    grp.eot   = 1'b1;
                    grp.err   = ERR_SEMICOLON;
                    mode_next = MODE_DONE;
                end
                else if (m1 == MODE_HASH && in_byte == CH_X) begin
                    mode_next = MODE_HEX;
                end
                else if (in_byte == CH_SEMI) begin
                    if (o0) begin
                        grp.count = 3'd1;
                        grp.err   = ERR_RANGE;
                    end
                    else begin
                        grp = utf8_encode(c0);
                    end
                    mode_next = MODE_TEXT;
                end
                else if ((m1 == MODE_HEX && !hexd[4]) || (m1 != MODE_HEX && is_dec)) begin
                    if (o0 || acc >= {4'd0, CODE_LIMIT}) begin
                        code_next = CODE_LIMIT;
                        ovf_next  = 1'b1;
                    end
                    else begin
                        code_next = acc[20:0];
                    end
                    if (m1 != MODE_HEX) begin
                        mode_next = MODE_DEC;
                    end
                end
                else begin
                    grp.count = 3'd1;
                    grp.err   = ERR_SEMICOLON;
                    mode_next = MODE_TEXT;
                end
            end
            MODE_DONE:
            begin
                mode_next = MODE_DONE;
            end
            default:
            begin
                mode_next = MODE_DONE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            mode_reg <= MODE_SKIP;
            len_reg  <= 3'd0;
            code_reg <= 21'd0;
            ovf_reg  <= 1'b0;
        end
        else if (take) begin
            mode_reg <= mode_next;
            len_reg  <= len_next;
            code_reg <= code_next;
            ovf_reg  <= ovf_next;
        end
    end

    // name characters hold no reset: only entries below the length are looked at
    always_ff @(posedge clk)
    begin
        if (take && char_we) begin
            chars_reg[l0[1:0]] <= in_byte;
        end
    end

    property p_len_bound;
        @(posedge clk) disable iff (!rst_n) len_reg <= 3'd4;
    endproperty
    a_len_bound: assert property (p_len_bound) else $error("entity length beyond four");

    property p_ovf_sat;
        @(posedge clk) disable iff (!rst_n) ovf_reg |-> (code_reg == CODE_LIMIT);
    endproperty
    a_ovf_sat: assert property (p_ovf_sat) else $error("overflow flag without saturation");

    property p_code_range;
        @(posedge clk) disable iff (!rst_n) !ovf_reg |-> (code_reg < CODE_LIMIT);
    endproperty
    a_code_range: assert property (p_code_range) else $error("code out of range unflagged");

endmodule

`default_nettype wire

>>> src/xtd_serialise.sv
// Result serialiser: holds one beat group and feeds an output register one beat at a time.
`default_nettype none

module xtd_serialise
    import xtd_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       grp_load,
    input  wire xtd_group_t grp,
    output logic            grp_ready,
    output logic            out_valid,
    input  wire logic       out_ready,
    output logic [7:0]      out_byte,
    output logic            byte_valid,
    output logic            end_of_text,
    output logic [1:0]      error_code,
    output logic            last_of_run
);

    xtd_group_t grp_reg;
    logic [2:0] cnt_reg, cnt_next;
    logic [1:0] idx_reg, idx_next;
    logic       out_valid_reg, out_valid_next;
    logic [7:0] byte_reg;
    logic       bvalid_reg, eot_reg, last_reg;
    logic [1:0] err_reg;
    logic       out_load;

    assign out_load  = (cnt_reg != 3'd0) && (!out_valid_reg || out_ready);
    assign grp_ready = (cnt_reg == 3'd0) || ((cnt_reg == 3'd1) && out_load);

    always_comb
    begin
        cnt_next = cnt_reg;
        idx_next = idx_reg;
        if (out_load) begin
            cnt_next = cnt_reg - 3'd1;
            idx_next = idx_reg + 2'd1;
        end
        if (grp_load) begin
            cnt_next = grp.count;
            idx_next = 2'd0;
        end

        if (out_load) begin
            out_valid_next = 1'b1;
        end
        else if (out_ready) begin
            out_valid_next = 1'b0;
        end
        else begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            cnt_reg       <= 3'd0;
            idx_reg       <= 2'd0;
            out_valid_reg <= 1'b0;
        end
        else begin
            cnt_reg       <= cnt_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (grp_load) begin
            grp_reg <= grp;
        end
        if (out_load) begin
            byte_reg   <= grp_reg.bytes[idx_reg];
            bvalid_reg <= grp_reg.valid;
            eot_reg    <= grp_reg.eot;
            err_reg    <= grp_reg.err;
            last_reg   <= (cnt_reg == 3'd1);
        end
    end

    assign out_valid   = out_valid_reg;
    assign out_byte    = byte_reg;
    assign byte_valid  = bvalid_reg;
    assign end_of_text = eot_reg;
    assign error_code  = err_reg;
    assign last_of_run = last_reg;

    property p_cnt_bound;
        @(posedge clk) disable iff (!rst_n) ({1'b0, cnt_reg} + {2'd0, idx_reg}) <= 4'd4;
    endproperty
    a_cnt_bound: assert property (p_cnt_bound) else $error("beat count past group end");

    property p_multi_plain;
        @(posedge clk) disable iff (!rst_n)
            (cnt_reg > 3'd1) |-> (grp_reg.valid && !grp_reg.eot && grp_reg.err == ERR_NONE);
    endproperty
    a_multi_plain: assert property (p_multi_plain) else $error("multi-beat group not plain");

    property p_rest_pending;
        @(posedge clk) disable iff (!rst_n) (out_valid_reg && !last_reg) |-> (cnt_reg != 3'd0);
    endproperty
    a_rest_pending: assert property (p_rest_pending) else $error("group ended without last");

    property p_no_overwrite;
        @(posedge clk) disable iff (!rst_n) grp_load |-> grp_ready;
    endproperty
    a_no_overwrite: assert property (p_no_overwrite) else $error("group overwritten");

endmodule

`default_nettype wire

>>> src/xml_text_entity_decoder.sv
// Top level of the XML text entity decoder: raw text bytes in, decoded UTF-8 beats out.
//
// Channel text (sink): one raw byte of a text run per beat; run_start marks the
// first byte of a run and clears the decoder state. Channel result (source):
// one decoded beat each, with byte_valid, end_of_text, error_code and
// last_of_run on the final beat caused by an input byte.
// A byte is decoded in the cycle it is taken; its beats land in a group
// register and move one per cycle, while the receiver does not stall, into the
// output register, so the first beat shows once it has passed both registers.
// Throughput: one input byte per cycle while each byte yields at most one beat
// and the receiver does not stall; a numeric reference that expands to more than
// one UTF-8 byte holds text.ready low while the group register drains. Bytes that
// yield nothing (leading space, reference characters) load nothing into it.
// When the receiver stalls, the output register holds its beat; an input byte
// that yields beats is still taken while the group register is empty, then text.ready falls.
// Reset empties both registers and returns the decoder to leading space skip.
`default_nettype none

module xml_text_entity_decoder
    import xtd_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    xtd_text_if.sink       text,
    xtd_result_if.source   result
);

    xtd_group_t grp;
    logic       take;
    logic       grp_ready;

    assign text.ready = grp_ready;
    assign take       = text.valid && grp_ready;

    xtd_decode u_decode (
        .clk       (clk),
        .rst_n     (rst_n),
        .take      (take),
        .in_byte   (text.in_byte),
        .run_start (text.run_start),
        .grp       (grp)
    );

    xtd_serialise u_serialise (
        .clk         (clk),
        .rst_n       (rst_n),
        .grp_load    (take && (grp.count != 3'd0)),
        .grp         (grp),
        .grp_ready   (grp_ready),
        .out_valid   (result.valid),
        .out_ready   (result.ready),
        .out_byte    (result.out_byte),
        .byte_valid  (result.byte_valid),
        .end_of_text (result.end_of_text),
        .error_code  (result.error_code),
        .last_of_run (result.last_of_run)
    );

endmodule

`default_nettype wire
